>>> rtl/core/s1md_pkg.sv
// ----------------------------------------------------------------------------
// s1md_pkg: shared types and constants of the SHA-1 digest unit
// Request and response payloads, the word passed from front to back, and
// the fixed constants of the algorithm.
// ----------------------------------------------------------------------------
package s1md_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // One big-endian message word on its way to the round engine.
   typedef struct packed {
      logic [31:0] word;
      logic        last_block;   // last word of the final padded block
   } msg_word_type;

   // Initial chaining values, entry 0 is h0.
   localparam logic [4:0][31:0] H_INIT = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK = 8'h80;

   // Last byte position before the length field, and the final position.
   localparam logic [5:0] POS_BEFORE_LEN = 6'd55;
   localparam logic [5:0] POS_LAST       = 6'd63;

   localparam logic [2:0] WORD_INDEX_LAST = 3'd4;

endpackage

>>> rtl/core/sha1_message_digest_unit.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_unit: streaming SHA-1 digest engine
// Takes a message one byte per request and returns the 160-bit digest as
// five 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Request side: drive req_data and raise push; a request is taken on a
//   clock edge with push high and full low. A request may carry no byte
//   (has_byte low); with last_byte high it closes the message, so an empty
//   message is one request with has_byte low and last_byte high.
//   Response side: while empty is low, rsp_data holds the oldest digest
//   word; pop takes it. Five words, h0 to h4, follow each message, the
//   fifth with last_word set.
//   Timing: the intake takes one byte per cycle while it is not padding
//   and the queue has room, and packs four into a word; padding and length
//   bytes (up to 72) also go at one byte per cycle while the queue has room.
//   The round engine loads the working words, runs the 80 SHA-1 rounds, one
//   per cycle, and folds the result into the chaining words for each 64-byte
//   block; the single round adder bounds the streaming rate. Rounds 0 to 15
//   wait on the word queue when it runs dry.
//   Reset: synchronous, clears the queue, the bit count and restores the
//   initial chaining words. A stalled response side holds the engine in
//   its output state; the intake keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module sha1_message_digest_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  s1md_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output s1md_pkg::rsp_type rsp_data
);

   logic                   q_wr_valid;
   s1md_pkg::msg_word_type q_wr_entry;
   logic                   q_wr_full;
   logic                   q_rd_pop;
   s1md_pkg::msg_word_type q_rd_entry;
   logic                   q_rd_empty;

   // Intake: pack bytes into words and append padding.
   s1md_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .wr_valid (q_wr_valid),
      .wr_entry (q_wr_entry),
      .wr_full  (q_wr_full)
   );

   // Decouple intake from the rounds; hold up to QUEUE_DEPTH words, one block at the default depth.
   s1md_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_wr_valid),
      .wr_entry (q_wr_entry),
      .wr_full  (q_wr_full),
      .rd_pop   (q_rd_pop),
      .rd_entry (q_rd_entry),
      .rd_empty (q_rd_empty)
   );

   // Round engine and digest output.
   s1md_back u_back (
      .clock    (clock),
      .reset    (reset),
      .rd_entry (q_rd_entry),
      .rd_empty (q_rd_empty),
      .rd_pop   (q_rd_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

>>> rtl/core/s1md_front.sv
// ----------------------------------------------------------------------------
// s1md_front: byte intake and padding
// Packs message bytes into big-endian words, generates the padding and
// length bytes after the end of a message, and hands words to the queue.
// ----------------------------------------------------------------------------
module s1md_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  s1md_pkg::req_type      req_data,
   output logic                   wr_valid,
   output s1md_pkg::msg_word_type wr_entry,
   input  logic                   wr_full
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MARK = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;
   localparam logic [1:0] ST_LEN  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;
   logic [23:0] acc_ff, acc_in;
   logic [63:0] bit_count_ff, bit_count_in;

   logic        accept;
   logic        emit;
   logic [7:0]  emit_byte;
   logic [63:0] len_shift;

   assign full      = (state_ff != ST_IDLE) || wr_full;
   assign accept    = push && !full;
   assign len_shift = bit_count_ff >> {~pos_ff[2:0], 3'b000};

   always_comb begin
      emit      = 1'b0;
      emit_byte = req_data.data_byte;
      case (state_ff)
         ST_IDLE: begin
            emit = accept && req_data.has_byte;
         end
         ST_MARK: begin
            emit      = !wr_full;
            emit_byte = s1md_pkg::PAD_MARK;
         end
         ST_ZERO: begin
            emit      = !wr_full;
            emit_byte = 8'h00;
         end
         ST_LEN: begin
            emit      = !wr_full;
            emit_byte = len_shift[7:0];
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign wr_valid            = emit && (pos_ff[1:0] == 2'b11);
   assign wr_entry.word       = {acc_ff, emit_byte};
   assign wr_entry.last_block = (state_ff == ST_LEN) && (pos_ff == s1md_pkg::POS_LAST);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      bit_count_in = bit_count_ff;
      if (emit) begin
         pos_in = pos_ff + 6'd1;
         acc_in = {acc_ff[15:0], emit_byte};
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.has_byte) begin
               bit_count_in = bit_count_ff + 64'd8;
            end
            if (accept && req_data.last_byte) begin
               state_in = ST_MARK;
            end
         end
         ST_MARK, ST_ZERO: begin
            if (emit && (pos_ff == s1md_pkg::POS_BEFORE_LEN)) begin
               state_in = ST_LEN;
            end else if (emit) begin
               state_in = ST_ZERO;
            end
         end
         ST_LEN: begin
            if (emit && (pos_ff == s1md_pkg::POS_LAST)) begin
               state_in     = ST_IDLE;
               bit_count_in = 64'd0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= 6'd0;
         bit_count_ff <= 64'd0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         bit_count_ff <= bit_count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

>>> rtl/core/s1md_queue.sv
// ----------------------------------------------------------------------------
// s1md_queue: word queue between intake and round engine
// A small first-in first-out store of message words.
// ----------------------------------------------------------------------------
module s1md_queue #(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_valid,
   input  s1md_pkg::msg_word_type wr_entry,
   output logic                   wr_full,
   input  logic                   rd_pop,
   output s1md_pkg::msg_word_type rd_entry,
   output logic                   rd_empty
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   s1md_pkg::msg_word_type entry_ff [DEPTH];
   logic [IW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   assign wr_full  = (count_ff == CW'(DEPTH));
   assign rd_empty = (count_ff == '0);
   assign rd_entry = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && !wr_full;
   assign do_rd    = rd_pop && !rd_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + IW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + IW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

>>> rtl/core/s1md_back.sv
// ----------------------------------------------------------------------------
// s1md_back: SHA-1 round engine
// Runs one round per cycle (rounds 0-15 wait on an empty queue) over each
// 16-word block, folds the result into the chaining words, presents the digest.
// ----------------------------------------------------------------------------
module s1md_back (
   input  logic                   clock,
   input  logic                   reset,
   input  s1md_pkg::msg_word_type rd_entry,
   input  logic                   rd_empty,
   output logic                   rd_pop,
   output logic                   empty,
   input  logic                   pop,
   output s1md_pkg::rsp_type      rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_FOLD  = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   localparam logic [6:0] ROUND_MSG_END = 7'd16;
   localparam logic [6:0] ROUND_G1      = 7'd20;
   localparam logic [6:0] ROUND_G2      = 7'd40;
   localparam logic [6:0] ROUND_G3      = 7'd60;
   localparam logic [6:0] ROUND_LAST_W  = 7'd15;
   localparam logic [6:0] ROUND_LAST    = 7'd79;

   logic [1:0]        state_ff, state_in;
   logic [6:0]        rnd_ff, rnd_in;
   logic [2:0]        idx_ff, idx_in;
   logic              last_ff, last_in;
   logic [4:0][31:0]  chain_ff, chain_in;
   logic [4:0][31:0]  work_ff, work_in;
   logic [15:0][31:0] sched_ff, sched_in;

   logic        in_msg, step;
   logic [31:0] w_mix, w_new, f, k, t;
   logic [31:0] a, b, c, d, e;

   assign a = work_ff[0];
   assign b = work_ff[1];
   assign c = work_ff[2];
   assign d = work_ff[3];
   assign e = work_ff[4];

   assign in_msg = (rnd_ff < ROUND_MSG_END);
   assign step   = (state_ff == ST_ROUND) && (!in_msg || !rd_empty);
   assign rd_pop = (state_ff == ST_ROUND) && in_msg && !rd_empty;

   assign w_mix = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
   assign w_new = in_msg ? rd_entry.word : {w_mix[30:0], w_mix[31]};

   always_comb begin
      if (rnd_ff < ROUND_G1) begin
         f = (b & c) | (~b & d);
         k = s1md_pkg::K_0;
      end else if (rnd_ff < ROUND_G2) begin
         f = b ^ c ^ d;
         k = s1md_pkg::K_1;
      end else if (rnd_ff < ROUND_G3) begin
         f = (b & c) | (b & d) | (c & d);
         k = s1md_pkg::K_2;
      end else begin
         f = b ^ c ^ d;
         k = s1md_pkg::K_3;
      end
   end

   assign t = {a[26:0], a[31:27]} + f + e + k + w_new;

   assign empty                = (state_ff != ST_OUT);
   assign rsp_data.digest_word = chain_ff[idx_ff];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last_word   = (idx_ff == s1md_pkg::WORD_INDEX_LAST);

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      sched_in = sched_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!rd_empty) begin
               work_in  = chain_ff;
               rnd_in   = 7'd0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (step) begin
               sched_in = {w_new, sched_ff[15:1]};
               work_in  = {d, c, {b[1:0], b[31:2]}, a, t};
               rnd_in   = rnd_ff + 7'd1;
               if (rnd_ff == ROUND_LAST_W) begin
                  last_in = rd_entry.last_block;
               end
               if (rnd_ff == ROUND_LAST) begin
                  state_in = ST_FOLD;
               end
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < 5; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            idx_in   = 3'd0;
            state_in = last_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (pop) begin
               if (idx_ff == s1md_pkg::WORD_INDEX_LAST) begin
                  chain_in = s1md_pkg::H_INIT;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= 7'd0;
         idx_ff   <= 3'd0;
         last_ff  <= 1'b0;
         chain_ff <= s1md_pkg::H_INIT;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         last_ff  <= last_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for sha1_message_digest_unit
// Streams byte messages of chosen and random lengths into the request queue,
// works out each digest with a built-in SHA-1 model and checks every
// response word in order, under several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
   import s1md_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 300000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int PHASE_REQUESTS = 20;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   // Model state: chaining words, current block and message length in bits.
   logic [31:0] hash_words [5];
   logic [7:0]  block_bytes [64];
   logic [63:0] message_bits;
   // Digest words still owed by the block, oldest first.
   rsp_type     digest_queue [$];

   int errors      = 0;
   int cycle_count = 0;
   int sender_idle = 0;   // percent of cycles the request side holds off
   int rsp_stall   = 0;   // percent of cycles the response side refuses

   sha1_message_digest_unit dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Guard against a hung block: give up well beyond the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // Run the 80 rounds over block_bytes and fold the result into hash_words.
   function automatic void compress_block();
      logic [31:0] sched [16];
      logic [31:0] a, b, c, d, e, f, k, t, w;
      a = hash_words[0];
      b = hash_words[1];
      c = hash_words[2];
      d = hash_words[3];
      e = hash_words[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 16) begin
            w = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                 block_bytes[4*i+3]};
         end else begin
            w = rotl(sched[(i-3) & 15] ^ sched[(i-8) & 15] ^ sched[(i-14) & 15]
                     ^ sched[i & 15], 1);
         end
         sched[i & 15] = w;
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = K_0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = K_1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_2;
         end else begin
            f = b ^ c ^ d;
            k = K_3;
         end
         t = rotl(a, 5) + f + e + k + w;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      hash_words[0] += a;
      hash_words[1] += b;
      hash_words[2] += c;
      hash_words[3] += d;
      hash_words[4] += e;
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < 5; i++) hash_words[i] = H_INIT[i];
      message_bits = '0;
   endfunction

   // Apply one accepted request; on a closing request pad, finish the hash
   // and queue the five digest words it must produce.
   function automatic void absorb_request(input req_type r);
      int unsigned pos;
      logic [63:0] length_bits;
      rsp_type     word;
      if (r.has_byte) begin
         pos = message_bits[8:3];
         block_bytes[pos] = r.data_byte;
         message_bits += 64'd8;
         if (pos == POS_LAST) compress_block();
      end
      if (!r.last_byte) return;
      length_bits = message_bits;
      pos = message_bits[8:3];
      block_bytes[pos] = PAD_MARK;
      pos++;
      // No room left for the length field: spill into an extra block.
      if (pos > POS_BEFORE_LEN + 1) begin
         while (pos < 64) begin
            block_bytes[pos] = 8'h00;
            pos++;
         end
         compress_block();
         pos = 0;
      end
      while (pos <= POS_BEFORE_LEN) begin
         block_bytes[pos] = 8'h00;
         pos++;
      end
      for (int i = 0; i < 8; i++) block_bytes[56+i] = length_bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 5; i++) begin
         word.digest_word = hash_words[i];
         word.word_index  = 3'(i);
         word.last_word   = (3'(i) == WORD_INDEX_LAST);
         digest_queue.insert(digest_queue.size(), word);
      end
      restart_message();
   endfunction

   // ------------------------------------------------------- request side

   // Hold off at random, then offer one request and wait for the block to take
   // it. Push stays high on return so back-to-back requests need no gap.
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < sender_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      req_data <= r;
      push     <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      absorb_request(r);
   endtask

   function automatic req_type make_request(input logic [7:0] data, input logic has,
                                            input logic closing);
      req_type r;
      r.data_byte = data;
      r.has_byte  = has;
      r.last_byte = closing;
      return r;
   endfunction

   // Pause the request side until every owed digest word has been taken.
   task automatic wait_for_digests();
      push <= 1'b0;
      @(posedge clock);
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   // One message of random bytes. Lengths favour the padding boundaries
   // around 55/56 and 63/64 bytes and the two-block range; empty requests
   // are sprinkled in as noise. Returns the number of requests that count.
   task automatic send_random_message(output int sent);
      int  len;
      int  pick;
      bit  close_on_byte;
      pick = $urandom_range(99);
      if (pick < 45)      len = $urandom_range(6);
      else if (pick < 75) len = $urandom_range(66, 53);
      else if (pick < 87) len = $urandom_range(122, 117);
      else                len = $urandom_range(70);
      close_on_byte = (len != 0) && $urandom_range(1);
      sent = 0;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 8)
            send_request(make_request(8'($urandom_range(255)), 1'b0, 1'b0));
         send_request(make_request(8'($urandom_range(255)), 1'b1,
                                   close_on_byte && (i == len - 1)));
         sent++;
      end
      if (!close_on_byte) begin
         send_request(make_request(8'($urandom_range(255)), 1'b0, 1'b1));
         sent++;
      end
   endtask

   // --------------------------------------------------------------- tests

   // Short known messages: the empty message, single extreme bytes, a byte
   // closing the message on the same request, and an empty closing request
   // after data with stray empty requests that must change nothing.
   task automatic test_directed_messages();
      sender_idle = 0;
      rsp_stall   = 0;
      send_request(make_request(8'h00, 1'b0, 1'b1));
      send_request(make_request(8'h00, 1'b1, 1'b1));
      send_request(make_request(8'hFF, 1'b1, 1'b1));
      send_request(make_request(8'h61, 1'b1, 1'b0));
      send_request(make_request(8'h62, 1'b1, 1'b0));
      send_request(make_request(8'h63, 1'b1, 1'b1));
      send_request(make_request(8'hA5, 1'b0, 1'b0));
      send_request(make_request(8'h61, 1'b1, 1'b0));
      send_request(make_request(8'hFF, 1'b0, 1'b0));
      send_request(make_request(8'h62, 1'b1, 1'b0));
      send_request(make_request(8'h63, 1'b1, 1'b0));
      send_request(make_request(8'h5A, 1'b0, 1'b1));
      send_request(make_request(8'hFF, 1'b1, 1'b0));
      send_request(make_request(8'h00, 1'b1, 1'b0));
      send_request(make_request(8'hFF, 1'b0, 1'b1));
      wait_for_digests();
   endtask

   // Random messages under one idling pattern, then drain before moving on.
   task automatic test_random_messages(input int idle_pct, input int stall_pct);
      int total;
      int sent;
      sender_idle = idle_pct;
      rsp_stall   = stall_pct;
      total = 0;
      while (total < PHASE_REQUESTS) begin
         send_random_message(sent);
         total += sent;
      end
      wait_for_digests();
   endtask

   // -------------------------------------------------------- response side

   // Take digest words at random and compare each against the oldest owed.
   always @(posedge clock) begin : check_digest
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest word, got %h", $time, rsp_data);
               errors++;
            end else begin
               want = digest_queue.pop_front();
               if (rsp_data.digest_word !== want.digest_word) begin
                  $display("%0t: digest_word expected %h got %h", $time,
                           want.digest_word, rsp_data.digest_word);
                  errors++;
               end
               if (rsp_data.word_index !== want.word_index) begin
                  $display("%0t: word_index expected %0d got %0d", $time,
                           want.word_index, rsp_data.word_index);
                  errors++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $display("%0t: last_word expected %b got %b", $time,
                           want.last_word, rsp_data.last_word);
                  errors++;
               end
            end
         end
         pop <= ($urandom_range(99) >= rsp_stall);
      end
   end

   // ---------------------------------------------------------------- run

   initial begin
      restart_message();
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_messages();
      test_random_messages(0, 0);
      test_random_messages(58, 0);
      test_random_messages(0, 58);
      test_random_messages(38, 38);

      // Let any stray words surface before the verdict.
      push <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sha1_message_digest_unit.f
rtl/core/s1md_pkg.sv
rtl/core/s1md_front.sv
rtl/core/s1md_queue.sv
rtl/core/s1md_back.sv
rtl/core/sha1_message_digest_unit.sv
tb/sv/tb.sv
